FILE: hdl/fov_pkg.sv
// Package for the find-or-insert value table: sizes, codes, types.
package fov_pkg;

  // table geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CFG_W       = 5;
  localparam int INDEX_W     = 4;
  localparam int LIMIT_RESET = (DEPTH < 16) ? DEPTH : 16;

  // request commands
  localparam logic CMD_FIND  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
    logic               done;
    logic               found;
    logic               added;
    logic [IDX_W-1:0]   idx;
  } link_t;

  // result of one request
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               found;
    logic               added;
    logic               full_res;
  } result_t;

endpackage

FILE: hdl/fov_if.sv
// Request and result channel interfaces of the find-or-insert value table.
interface fov_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [fov_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface fov_out_if;
  logic                        valid;
  logic                        ready;
  logic [fov_pkg::INDEX_W-1:0] index;
  logic                        found;
  logic                        added;
  logic                        full_res;

  modport source (output valid, output index, output found, output added,
                  output full_res, input ready);
  modport sink   (input valid, input index, input found, input added,
                  input full_res, output ready);
endinterface

FILE: hdl/fov_cell.sv
// One table cell: holds one entry and moves the search token one step.
module fov_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fov_pkg::IDX_W-1:0] cell_idx,
  input  logic [fov_pkg::CNT_W-1:0] count,
  input  logic [fov_pkg::CNT_W-1:0] limit,
  input  fov_pkg::link_t            link_in,
  output fov_pkg::link_t            link_out
);

  logic [fov_pkg::VALUE_W-1:0] entry_r;
  fov_pkg::link_t              link_r;
  fov_pkg::link_t              link_nxt;
  logic                        wr_en;
  logic [fov_pkg::CNT_W-1:0]   pos;

  assign pos = fov_pkg::CNT_W'(cell_idx);

  // compare against an occupied entry, or claim the first free slot while the count is below the limit
  always_comb begin
    link_nxt = link_in;
    wr_en    = 1'b0;
    if (link_in.vld && !link_in.done) begin
      priority if (pos < count) begin
        if (entry_r == link_in.value) begin
          link_nxt.done  = 1'b1;
          link_nxt.found = 1'b1;
          link_nxt.idx   = cell_idx;
        end
      end else if (pos == count) begin
        link_nxt.done = 1'b1;
        if (count < limit) begin
          link_nxt.added = 1'b1;
          link_nxt.idx   = cell_idx;
          wr_en          = 1'b1;
        end
      end else begin
        link_nxt = link_in;
      end
    end
  end

  // advance the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.vld <= 1'b0;
    end else begin
      link_r.vld <= link_nxt.vld;
    end
    link_r.value <= link_nxt.value;
    link_r.done  <= link_nxt.done;
    link_r.found <= link_nxt.found;
    link_r.added <= link_nxt.added;
    link_r.idx   <= link_nxt.idx;
  end

  // store the inserted value
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= link_in.value;
    end
  end

  assign link_out = link_r;

endmodule

FILE: hdl/find_or_insert_value_table.sv
// Top level of the find-or-insert value table.
// Usage:
//   in_req (valid/ready) carries one request: cmd and value. A find request
//   searches the occupied entries in order and returns the lowest matching
//   index with found set; with no match it stores the value at the next
//   free slot (added) while the fill count is below capacity_limit, else it
//   returns full_res. A clear request zeroes the fill count.
//   out_res (valid/ready) returns exactly one result per request.
//   cfg_we/cfg_wdata write capacity_limit; values above the depth act as
//   the depth. Write it only while the block is idle.
// Timing:
//   A find request travels down a chain of DEPTH cells, one cell per cycle,
//   and its result is registered at the end of the chain. A clear result is
//   registered in the output register, or in the holding register on a stall.
//   One request is in flight at a time: a new one is taken only when idle.
//   The request channel is ready again once the result has left the chain,
//   even while that result still waits in the output register.
// Reset and stall:
//   Reset empties the table and sets capacity_limit to 16. A stalled
//   receiver holds the result steady; a second finished result waits in
//   a holding register and no new request is taken until it moves on.
module find_or_insert_value_table (
  input  logic                      clk,
  input  logic                      rst_n,
  fov_in_if.sink                    in_req,
  fov_out_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic [fov_pkg::CFG_W-1:0] cfg_wdata
);

  fov_pkg::state_t           state_r;
  fov_pkg::state_t           state_nxt;
  logic [fov_pkg::CNT_W-1:0] count_r;
  logic [fov_pkg::CNT_W-1:0] limit_r;
  fov_pkg::link_t            links [fov_pkg::DEPTH+1];
  fov_pkg::link_t            tail;
  fov_pkg::result_t          res;
  fov_pkg::result_t          pend_r;
  fov_pkg::result_t          out_r;
  logic                      out_valid_r;
  logic                      accept;
  logic                      is_clear;
  logic                      done;
  logic                      out_free;

  assign accept   = in_req.valid && in_req.ready;
  assign is_clear = (in_req.cmd == fov_pkg::CMD_CLEAR);
  assign tail     = links[fov_pkg::DEPTH];
  assign done     = (accept && is_clear) || tail.vld;
  assign out_free = !out_valid_r || out_res.ready;

  // inject a find request at the head of the chain
  always_comb begin
    links[0]       = '0;
    links[0].vld   = accept && !is_clear;
    links[0].value = in_req.value;
  end

  // row of cells
  for (genvar k = 0; k < fov_pkg::DEPTH; k++) begin : g_cell
    fov_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (fov_pkg::IDX_W'(k)),
      .count    (count_r),
      .limit    (limit_r),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );
  end

  // form the result; an unresolved token means no room
  always_comb begin
    res = '0;
    if (tail.vld) begin
      res.found    = tail.found;
      res.added    = tail.added;
      res.full_res = !tail.found && !tail.added;
      if (tail.found || tail.added) begin
        res.index = fov_pkg::INDEX_W'(tail.idx);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fov_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_clear) begin
            state_nxt = fov_pkg::ST_SEARCH;
          end else if (!out_free) begin
            state_nxt = fov_pkg::ST_HOLD;
          end
        end
      end
      fov_pkg::ST_SEARCH: begin
        if (tail.vld) begin
          state_nxt = out_free ? fov_pkg::ST_IDLE : fov_pkg::ST_HOLD;
        end
      end
      fov_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = fov_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fov_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_req.ready = (state_r == fov_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fov_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fill count and capacity limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= fov_pkg::CNT_W'(fov_pkg::LIMIT_RESET);
    end else begin
      if (accept && is_clear) begin
        count_r <= '0;
      end else if (tail.vld && tail.added) begin
        count_r <= count_r + 1'b1;
      end
      if (cfg_we) begin
        if (32'(cfg_wdata) > 32'(fov_pkg::DEPTH)) begin
          limit_r <= fov_pkg::CNT_W'(fov_pkg::DEPTH);
        end else begin
          limit_r <= fov_pkg::CNT_W'(cfg_wdata);
        end
      end
    end
  end

  // output register and holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= done || (state_r == fov_pkg::ST_HOLD);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state_r == fov_pkg::ST_HOLD) begin
        out_r <= pend_r;
      end else begin
        out_r <= res;
      end
    end else if (done) begin
      pend_r <= res;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.index    = out_r.index;
  assign out_res.found    = out_r.found;
  assign out_res.added    = out_r.added;
  assign out_res.full_res = out_r.full_res;

endmodule

FILE: hdl/fov_checker.sv
// Port-level checker for the find-or-insert value table, with its bind.
module fov_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fov_pkg::INDEX_W-1:0] out_index,
  input logic                        out_found,
  input logic                        out_added,
  input logic                        out_full_res
);

  // at most one outcome flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_found, out_added, out_full_res}) <= 1)
    else $error("result carries more than one outcome flag");

  // index is zero unless an entry was found or added
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found && !out_added) |-> (out_index == '0))
    else $error("nonzero index without found or added");

  // a find request blocks the next request while it searches
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == fov_pkg::CMD_FIND) |=> !in_ready)
    else $error("request taken while a search is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) &&
      $stable(out_found) && $stable(out_added) && $stable(out_full_res)))
    else $error("stalled result changed");

endmodule

bind find_or_insert_value_table fov_checker u_fov_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .in_cmd       (in_req.cmd),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_index    (out_res.index),
  .out_found    (out_res.found),
  .out_added    (out_res.added),
  .out_full_res (out_res.full_res)
);

FILE: tb/tb_find_or_insert_value_table.sv
`timescale 1ns / 100ps
// Testbench for the find-or-insert value table: a queued driver, a checking monitor, a table model.
module tb_find_or_insert_value_table;
  import fov_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } request_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fov_in_if  req_if ();
  fov_out_if res_if ();

  find_or_insert_value_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // table model: stored values, fill count and capacity limit
  logic [VALUE_W-1:0] stored_values[DEPTH];
  int                 fill_count = 0;
  int                 capacity_limit = 16;

  request_t pending_lookups[$];
  result_t  expected_answers[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       error_count = 0;

  // apply one request to the table model and return its answer
  function automatic result_t lookup_or_insert(logic cmd, logic [VALUE_W-1:0] value);
    result_t res;
    int      eff_limit;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      fill_count = 0;
      return res;
    end
    eff_limit = (capacity_limit > DEPTH) ? DEPTH : capacity_limit;
    for (int i = 0; i < fill_count; i++) begin
      if (stored_values[i] == value) begin
        res.index = INDEX_W'(i);
        res.found = 1'b1;
        return res;
      end
    end
    if (fill_count < eff_limit) begin
      stored_values[fill_count] = value;
      res.index = INDEX_W'(fill_count);
      res.added = 1'b1;
      fill_count++;
      return res;
    end
    res.full_res = 1'b1;
    return res;
  endfunction

  // driver: predict on acceptance, then present the next queued request
  always @(posedge clk) begin
    logic     fire;
    logic     launch;
    request_t nxt;
    fire = req_if.valid && req_if.ready;
    launch = 1'b0;
    nxt.cmd = 1'($urandom);
    nxt.value = $urandom;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (fire) expected_answers.push_back(lookup_or_insert(req_if.cmd, req_if.value));
      if (fire || !req_if.valid) begin
        if (pending_lookups.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_lookups.pop_front();
          launch = 1'b1;
        end
        req_if.valid <= launch;
        req_if.cmd   <= nxt.cmd;
        req_if.value <= nxt.value;
      end
    end
  end

  // monitor: check each accepted result against the oldest answer, stall at random
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_answers.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (res_if.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, res_if.index);
            error_count++;
          end
          if (res_if.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, res_if.found);
            error_count++;
          end
          if (res_if.added !== want.added) begin
            $error("added: expected %0b, got %0b", want.added, res_if.added);
            error_count++;
          end
          if (res_if.full_res !== want.full_res) begin
            $error("full_res: expected %0b, got %0b", want.full_res, res_if.full_res);
            error_count++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_request(logic cmd, logic [VALUE_W-1:0] value);
    request_t r;
    r.cmd = cmd;
    r.value = value;
    pending_lookups.push_back(r);
  endtask

  // hold until every request is sent and every answer is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_lookups.size() != 0 || req_if.valid || expected_answers.size() != 0);
  endtask

  task automatic write_limit(int limit);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(limit);
    capacity_limit = limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus: directed fill and overflow, then random phases at several limits
  initial begin
    int                 phase_limits[10] = '{31, 0, 5, 1, 17, 16, 3, 8, 2, 16};
    int                 send_pct[4] = '{0, 82, 0, 24};
    int                 recv_pct[4] = '{0, 0, 82, 24};
    logic [VALUE_W-1:0] value_pool[20];
    int                 roll;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_FIND;
    req_if.value = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // clear on empty, both value extremes, hits, fill to depth, overflow, stale after clear
    queue_request(CMD_CLEAR, '0);
    queue_request(CMD_FIND, '0);
    queue_request(CMD_FIND, '1);
    queue_request(CMD_FIND, '0);
    queue_request(CMD_FIND, '1);
    for (int i = 0; i < DEPTH - 2; i++) queue_request(CMD_FIND, 32'h1000_0000 + i);
    queue_request(CMD_FIND, 32'h5555_AAAA);
    queue_request(CMD_FIND, 32'h1000_0000 + DEPTH - 3);
    queue_request(CMD_CLEAR, '1);
    queue_request(CMD_FIND, 32'h1000_0005);
    queue_request(CMD_FIND, '1);
    wait_drained();

    // random phases, each with its own limit and idle pattern
    for (int p = 0; p < 10; p++) begin
      write_limit(phase_limits[p]);
      send_idle_pct  = send_pct[p % 4];
      recv_stall_pct = recv_pct[p % 4];
      foreach (value_pool[k]) value_pool[k] = $urandom;
      for (int n = 0; n < 130; n++) begin
        roll = $urandom_range(99);
        if (roll < 5)
          queue_request(CMD_CLEAR, $urandom);
        else if (roll < 70)
          queue_request(CMD_FIND, value_pool[$urandom_range(19)]);
        else
          queue_request(CMD_FIND, $urandom);
      end
      wait_drained();
    end

    repeat (DEPTH + 4) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("tb_find_or_insert_value_table: done, clean");
    end else begin
      if (expected_answers.size() != 0)
        $error("%0d answers never arrived", expected_answers.size());
      $display("tb_find_or_insert_value_table: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_find_or_insert_value_table: done, errors");
    $finish;
  end

endmodule
